@@ rtl/hndp_pkg.sv @@
// ----------------------------------------------------------------------------
// hndp_pkg
// Shared types, codes and helpers of the near-duplicate hash pair finder.
// ----------------------------------------------------------------------------
package hndp_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int MAX_RESULTS     = 63;
    localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

    localparam int HASH_W = 64;
    localparam int ID_W   = 16;
    localparam int DIST_W = 7;
    localparam int ST_W   = 2;

    localparam logic [ST_W-1:0] ST_PAIR  = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_CLEAR = 2'd3;

    localparam logic [1:0] K_ADD      = 2'd0;
    localparam logic [1:0] K_ADD_ZERO = 2'd1;
    localparam logic [1:0] K_CLEAR    = 2'd2;

    localparam int IQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    localparam logic [DIST_W-1:0] THR_RESET = 7'd10;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_MATCH_THRESHOLD = 1'b0;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   image_id;
        logic [HASH_W-1:0] hash_value;
    } t_item;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   earlier_id;
        logic [ID_W-1:0]   newer_id;
        logic [DIST_W-1:0] distance;
        logic              last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ID_W-1:0]   id;
        logic [HASH_W-1:0] hash;
    } t_front_item;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [HASH_W-1:0] hash;
    } t_entry;

    function automatic logic [DIST_W-1:0] popcount64(input logic [HASH_W-1:0] v);
        logic [1:0] l1 [32];
        logic [2:0] l2 [16];
        logic [3:0] l3 [8];
        logic [4:0] l4 [4];
        logic [5:0] l5 [2];
        for (int i = 0; i < 32; i++) l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        for (int i = 0; i < 16; i++) l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        for (int i = 0; i < 8; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        for (int i = 0; i < 4; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        for (int i = 0; i < 2; i++)  l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        return {1'b0, l5[0]} + {1'b0, l5[1]};
    endfunction

endpackage

@@ rtl/hndp_front.sv @@
// ----------------------------------------------------------------------------
// hndp_front
// Input queue: accepts items, tags each as add, zero-hash add or clear.
// ----------------------------------------------------------------------------
module hndp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  hndp_pkg::t_item       i_item,
    output logic                  o_full,
    output logic                  o_valid,
    output hndp_pkg::t_front_item o_head,
    input  logic                  i_pop
);
    import hndp_pkg::*;

    localparam int PW = $clog2(IQ_DEPTH);

    t_front_item    r_mem [IQ_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;
    t_front_item    n_entry;
    logic           push_ok;
    logic           pop_ok;

    always_comb begin
        n_entry.id   = i_item.image_id;
        n_entry.hash = i_item.hash_value;
        if (i_item.mode) begin
            n_entry.kind = K_CLEAR;
        end else if (i_item.hash_value == '0) begin
            n_entry.kind = K_ADD_ZERO;
        end else begin
            n_entry.kind = K_ADD;
        end
    end

    assign o_full  = (r_cnt == (PW+1)'(IQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 1'b1;
            if (pop_ok)  r_rp <= r_rp + 1'b1;
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/hndp_back.sv @@
// ----------------------------------------------------------------------------
// hndp_back
// Search engine: scans the hash table one entry a cycle while the result
// queue has room, reports pairs, appends the new entry; clear and table-full items get one result.
// ----------------------------------------------------------------------------
module hndp_back #(
    parameter int TABLE_DEPTH = hndp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  hndp_pkg::t_front_item         i_head,
    output logic                          o_pop,
    input  logic [hndp_pkg::DIST_W-1:0]   i_threshold,
    input  logic [hndp_pkg::OQ_CW-1:0]    i_oq_count,
    output logic                          o_push,
    output hndp_pkg::t_result             o_result
);
    import hndp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    t_entry             r_table [TABLE_DEPTH];
    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [FW-1:0]      r_fill;
    logic [FW-1:0]      r_rd_idx;
    logic               r_skip;
    logic [ID_W-1:0]    r_new_id;
    logic [HASH_W-1:0]  r_new_hash;
    logic               r_v1;
    t_entry             r_rd_data;
    logic               r_v2;
    logic [DIST_W-1:0]  r_dist;
    logic [ID_W-1:0]    r_s2_id;
    logic               r_s2_nz;
    logic               r_pend_v;
    logic [ID_W-1:0]    r_pend_id;
    logic [DIST_W-1:0]  r_pend_dist;
    logic [CNT_W-1:0]   r_pairs;

    logic [OQ_CW-1:0]   oq_free;
    logic [1:0]         inflight;
    logic               oq_room;
    logic               scan_done;
    logic               issue;
    logic               match;
    logic               head_clear;
    logic               head_full;
    logic               start;
    logic               fin_write;

    assign oq_free    = OQ_CW'(OQ_DEPTH) - i_oq_count;
    assign inflight   = {1'b0, r_v1} + {1'b0, r_v2};
    assign oq_room    = (oq_free != '0);
    assign scan_done  = r_skip || (r_rd_idx == r_fill);
    assign issue      = (r_state == S_SCAN) && !scan_done && (oq_free > OQ_CW'(inflight));
    assign match      = r_v2 && r_s2_nz && (r_dist <= i_threshold)
                        && (r_pairs < CNT_W'(MAX_RESULTS));
    assign head_clear = (i_head.kind == K_CLEAR);
    assign head_full  = !head_clear && (r_fill == FW'(TABLE_DEPTH));
    assign start      = (r_state == S_IDLE) && i_valid && !head_clear && !head_full;
    assign fin_write  = (r_state == S_FIN) && oq_room;

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        o_push   = 1'b0;
        o_result = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (head_clear || head_full) begin
                        if (oq_room) begin
                            o_pop                = 1'b1;
                            o_push               = 1'b1;
                            o_result.status      = head_clear ? ST_CLEAR : ST_FULL;
                            o_result.last_of_run = 1'b1;
                        end
                    end else begin
                        o_pop   = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (match && r_pend_v) begin
                    o_push              = 1'b1;
                    o_result.status     = ST_PAIR;
                    o_result.earlier_id = r_pend_id;
                    o_result.newer_id   = r_new_id;
                    o_result.distance   = r_pend_dist;
                end
                if (scan_done && !r_v1 && !r_v2) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (oq_room) begin
                    o_push               = 1'b1;
                    o_result.last_of_run = 1'b1;
                    if (r_pend_v) begin
                        o_result.status     = ST_PAIR;
                        o_result.earlier_id = r_pend_id;
                        o_result.newer_id   = r_new_id;
                        o_result.distance   = r_pend_dist;
                    end else begin
                        o_result.status = ST_NONE;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fin_write) begin
            r_table[r_fill[AW-1:0]] <= '{id: r_new_id, hash: r_new_hash};
        end
        if (issue) begin
            r_rd_data <= r_table[r_rd_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_new_id   <= i_head.id;
            r_new_hash <= i_head.hash;
        end
        if (r_v1) begin
            r_dist  <= popcount64(r_rd_data.hash ^ r_new_hash);
            r_s2_id <= r_rd_data.id;
            r_s2_nz <= (r_rd_data.hash != '0);
        end
        if (match) begin
            r_pend_id   <= r_s2_id;
            r_pend_dist <= r_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_rd_idx <= '0;
            r_skip   <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_pend_v <= 1'b0;
            r_pairs  <= '0;
        end else begin
            r_state <= n_state;
            r_v1    <= issue;
            r_v2    <= r_v1;
            if (issue) r_rd_idx <= r_rd_idx + 1'b1;
            if (match) begin
                r_pend_v <= 1'b1;
                r_pairs  <= r_pairs + 1'b1;
            end
            if ((r_state == S_IDLE) && i_valid && head_clear && oq_room) begin
                r_fill <= '0;
            end
            if (start) begin
                r_rd_idx <= '0;
                r_skip   <= (i_head.kind == K_ADD_ZERO);
                r_pend_v <= 1'b0;
                r_pairs  <= '0;
            end
            if (fin_write) begin
                r_fill   <= r_fill + 1'b1;
                r_pend_v <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/hndp_outq.sv @@
// ----------------------------------------------------------------------------
// hndp_outq
// Result queue between the search engine and the result port.
// ----------------------------------------------------------------------------
module hndp_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  hndp_pkg::t_result           i_data,
    output logic                        o_full,
    output logic [hndp_pkg::OQ_CW-1:0]  o_count,
    output logic                        o_valid,
    output hndp_pkg::t_result           o_data,
    input  logic                        i_pop
);
    import hndp_pkg::*;

    localparam int PW = $clog2(OQ_DEPTH);

    t_result        r_mem [OQ_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;
    logic           push_ok;
    logic           pop_ok;

    assign o_full  = (r_cnt == (PW+1)'(OQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_count = OQ_CW'(r_cnt);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 1'b1;
            if (pop_ok)  r_rp <= r_rp + 1'b1;
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/hash_near_duplicate_pair_finder.sv @@
// ----------------------------------------------------------------------------
// hash_near_duplicate_pair_finder
// Finds stored 64-bit hashes within a Hamming distance of each new hash.
//
// Input side is a queue: an item transfers when push is high and full is
// low. Mode 0 adds an entry and searches the table, mode 1 clears it.
// Result side is a queue: the oldest result sits on o_result while empty
// is low and transfers when pop is high. Each input yields one or more
// results; the last one carries last_of_run.
// An add walks the stored entries through one memory read port, one entry
// per cycle while the result queue has room; a zero-hash add skips the
// walk. A two-entry input queue lets the next item transfer while the
// current one is searched.
// When the receiver stalls, results collect in a four-entry queue and the
// table walk pauses until room frees up; nothing is dropped.
// Reset empties the table (fill count zero, no clearing pass) and sets
// match_threshold to 10. match_threshold sits at byte address 0 of the
// APB port.
// ----------------------------------------------------------------------------
module hash_near_duplicate_pair_finder #(
    parameter int TABLE_DEPTH = hndp_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    input  hndp_pkg::t_item              i_item,
    output logic                         full,
    output logic                         empty,
    input  logic                         pop,
    output hndp_pkg::t_result            o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hndp_pkg::APB_AW-1:0]  paddr,
    input  logic [hndp_pkg::APB_DW-1:0]  pwdata,
    output logic [hndp_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import hndp_pkg::*;

    logic [DIST_W-1:0]  r_threshold;
    logic               cfg_wr;
    logic               fr_valid;
    t_front_item        fr_head;
    logic               fr_pop;
    logic               bk_push;
    t_result            bk_result;
    logic               oq_full;
    logic [OQ_CW-1:0]   oq_count;
    logic               oq_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (cfg_wr && (paddr[2] == REG_MATCH_THRESHOLD)) begin
            r_threshold <= pwdata[DIST_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MATCH_THRESHOLD) begin
            prdata[DIST_W-1:0] = r_threshold;
        end
    end

    hndp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .o_valid (fr_valid),
        .o_head  (fr_head),
        .i_pop   (fr_pop)
    );

    hndp_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (fr_valid),
        .i_head      (fr_head),
        .o_pop       (fr_pop),
        .i_threshold (r_threshold),
        .i_oq_count  (oq_count),
        .o_push      (bk_push),
        .o_result    (bk_result)
    );

    hndp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_push),
        .i_data  (bk_result),
        .o_full  (oq_full),
        .o_count (oq_count),
        .o_valid (oq_valid),
        .o_data  (o_result),
        .i_pop   (pop)
    );

    assign empty = !oq_valid;

    a_no_result_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_push |-> !oq_full)
        else $error("result queue overflow");

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_pop |-> fr_valid)
        else $error("input queue popped while empty");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_single_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.status != ST_PAIR)) |-> o_result.last_of_run)
        else $error("non-pair result without last_of_run");

    a_threshold_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && (paddr[2] == REG_MATCH_THRESHOLD))
            |=> (r_threshold == $past(pwdata[DIST_W-1:0])))
        else $error("threshold write lost");

endmodule
